/* design/tad_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tad_pkg;

  localparam int unsigned MAX_READINGS_DEF = 255;

  localparam int unsigned RAW_W   = 10;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned MAG_W   = 18;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned VAL_W   = 22;
  localparam int unsigned DIGITS  = 5;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned STR_LEN = 14;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned STEP_W  = 5;

  // one quotient bit per division step, one value bit per conversion step
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned BCD_STEPS = VAL_W;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_C     = 8'h43;

  localparam logic [IDX_W-1:0] POS_SIGN = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_D100 = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_D10  = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_D1   = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_F10  = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_F100 = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(STR_LEN - 1);

  localparam logic [7:0] TEMPLATE [STR_LEN] = '{
    8'h54, 8'h45, 8'h4D, 8'h50, 8'h3A, CH_PLUS, CH_ZERO,
    CH_ZERO, CH_ZERO, 8'h2C, CH_ZERO, CH_ZERO, CH_SPACE, CH_C
  };

  typedef struct packed {
    logic             acc;        // add a reading
    logic             start;      // latch magnitude, clear accumulators
    logic             div_step;
    logic             mul;
    logic             bcd_step;
    logic             emit_load;
    logic [IDX_W-1:0] char_idx;
  } tad_cmd_t;

  function automatic logic [7:0] char_of(input logic [IDX_W-1:0] idx,
                                         input logic neg,
                                         input logic [BCD_W-1:0] bcd);
    logic [7:0] ch;
    ch = CH_SPACE;
    case (idx)
      POS_SIGN: ch = neg ? CH_MINUS : CH_PLUS;
      POS_D100: ch = CH_ZERO + {4'd0, bcd[19:16]};
      POS_D10:  ch = CH_ZERO + {4'd0, bcd[15:12]};
      POS_D1:   ch = CH_ZERO + {4'd0, bcd[11:8]};
      POS_F10:  ch = CH_ZERO + {4'd0, bcd[7:4]};
      POS_F100: ch = CH_ZERO + {4'd0, bcd[3:0]};
      default: begin
        if (idx <= POS_LAST) ch = TEMPLATE[idx];
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

/* design/tad_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               cmd_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output tad_pkg::tad_cmd_t  ctrl_o
);
  import tad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_BCD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              load;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    idx_d    = idx_q;
    ctrl_o   = '0;
    ctrl_o.char_idx = idx_q;
    case (state_q)
      S_IDLE: begin
        ctrl_o.acc   = accept && !cmd_i;
        ctrl_o.start = accept && cmd_i;
        if (accept && cmd_i) begin
          state_d = S_DIV;
          step_d  = '0;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d = S_BCD;
        step_d  = '0;
      end
      S_BCD: begin
        ctrl_o.bcd_step = 1'b1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(BCD_STEPS - 1)) begin
          state_d = S_EMIT;
          idx_d   = '0;
        end
      end
      S_EMIT: begin
        ctrl_o.emit_load = load;
        if (load) begin
          idx_d = idx_q + IDX_W'(1);
          if (idx_q == POS_LAST) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold the result until the far side takes it
  assign out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* design/tad_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tad_datapath #(
  parameter int unsigned MAX_READINGS = tad_pkg::MAX_READINGS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tad_pkg::tad_cmd_t         ctrl_i,
  input  logic [tad_pkg::RAW_W-1:0] reading_i,
  output logic [7:0]                text_char_o,
  output logic                      last_char_o
);
  import tad_pkg::*;

  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        count_q;
  logic                    neg_q;
  logic [MAG_W-1:0]        dvd_q;
  logic [CNT_W-1:0]        rem_q;
  logic [CNT_W-1:0]        dvs_q;
  logic [VAL_W-1:0]        val_q;
  logic [BCD_W-1:0]        bcd_q;
  logic [7:0]              text_char_q;
  logic                    last_char_q;

  logic signed [SUM_W-1:0] sext;
  logic signed [SUM_W-1:0] neg_sum;
  logic [MAG_W-1:0]        mag;
  logic [CNT_W:0]          rem_sh;
  logic [CNT_W:0]          rem_sub;
  logic                    q_bit;
  logic [VAL_W-1:0]        val_mul;
  logic [BCD_W-1:0]        bcd_adj;

  assign sext    = {{(SUM_W - RAW_W){reading_i[RAW_W-1]}}, reading_i};
  assign neg_sum = -sum_q;
  assign mag     = sum_q[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_q[MAG_W-1:0];

  // restoring division, one quotient bit a cycle shifted into dvd_q
  assign rem_sh  = {rem_q, dvd_q[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign q_bit   = (rem_sh >= {1'b0, dvs_q});

  // times 25 as 16q + 8q + q
  assign val_mul = {dvd_q, 4'd0} + VAL_W'({dvd_q, 3'd0}) + VAL_W'(dvd_q);

  // add three to any digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                    : bcd_q[4*d +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (ctrl_i.start) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (ctrl_i.acc && (count_q < CNT_W'(MAX_READINGS))) begin
      sum_q   <= sum_q + sext;
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q <= sum_q[SUM_W-1];
      rem_q <= '0;
      // an empty average divides zero by one
      if (count_q == '0) begin
        dvd_q <= '0;
        dvs_q <= CNT_W'(1);
      end else begin
        dvd_q <= mag;
        dvs_q <= count_q;
      end
    end else if (ctrl_i.div_step) begin
      rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd_q <= {dvd_q[MAG_W-2:0], q_bit};
    end

    if (ctrl_i.mul) begin
      val_q <= val_mul;
      bcd_q <= '0;
    end else if (ctrl_i.bcd_step) begin
      // digits above the fifth drop off the top
      bcd_q <= {bcd_adj[BCD_W-2:0], val_q[VAL_W-1]};
      val_q <= {val_q[VAL_W-2:0], 1'b0};
    end

    if (ctrl_i.emit_load) begin
      text_char_q <= char_of(ctrl_i.char_idx, neg_q, bcd_q);
      last_char_q <= (ctrl_i.char_idx == POS_LAST);
    end
  end

  assign text_char_o = text_char_q;
  assign last_char_o = last_char_q;

endmodule

`default_nettype wire

/* design/temperature_average_ascii_display.sv */
// Accumulate transaction: taken without stalling the input, the next transaction may follow directly.
// Display transaction: a load step, the division steps (one quotient bit each),
// a multiply step and the BCD conversion steps, then 14 characters from the
// output register at one per cycle when not stalled.
// Input stall stays high from the display command until the last character is loaded.
// Reset (asynchronous, active low) clears the sum, the count and all control state.
`timescale 1ns / 1ps
`default_nettype none

module temperature_average_ascii_display #(
  parameter int unsigned MAX_READINGS = tad_pkg::MAX_READINGS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [tad_pkg::RAW_W-1:0] reading_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                text_char_o,
  output logic                      last_char_o
);
  import tad_pkg::*;

  tad_cmd_t ctrl;

  tad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  tad_datapath #(
    .MAX_READINGS (MAX_READINGS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .reading_i   (reading_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  a_display_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i) |=> in_stall_o)
    else $error("display transaction did not stall the input");

  a_acc_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !cmd_i) |=> !in_stall_o)
    else $error("accumulate transaction stalled the input");

  a_last_is_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_char_o) |-> (text_char_o == CH_C))
    else $error("last character is not the closing letter");

endmodule

`default_nettype wire
